// ===== rtl/tcgr_pkg.sv =====
// types, constants and codes shared by the text cell glyph renderer
// no dependencies; imported by the renderer and the pixel serialiser, not by the ram

package tcgr_pkg;

	// widths fixed by the request and pixel formats
	localparam int OPCODE_W    = 2;
	localparam int LOAD_ADDR_W = 12;
	localparam int COLOR_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int ROW_W       = 6;
	localparam int COL_W       = 7;
	localparam int SCAN_W      = 4;
	localparam int GLYPH_W     = 8;
	localparam int PIX_IDX_W   = 3;
	localparam int POS_W       = 10;

	// configuration registers
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_SEL    = 1'b1;

	// screen and cell limits
	localparam int GLYPH_LINES_DEF     = 16;
	localparam int MAX_ROWS            = 64;
	localparam int MAX_COLUMNS         = 128;
	localparam int DEFAULT_CELL_HEIGHT = 16;
	localparam int HEIGHT_W            = 6;
	localparam int Y_FULL_W            = ROW_W + HEIGHT_W + 1;
	localparam int PALETTE_DEPTH       = 16;
	localparam logic [CFG_W-1:0] CELL_HEIGHT_RST = 5'd16;

	localparam logic [PIX_IDX_W-1:0] PIX_LAST = 3'd7;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD_PRI = 2'd0,
		OP_LOAD_SEC = 2'd1,
		OP_LOAD_PAL = 2'd2,
		OP_RENDER   = 2'd3
	} opcode_e;

	typedef struct packed {
		logic [OPCODE_W-1:0]    opcode;
		logic [LOAD_ADDR_W-1:0] load_address;
		logic [COLOR_W-1:0]     load_value;
		logic [CHAR_W-1:0]      character_code;
		logic [ATTR_W-1:0]      attribute_byte;
		logic [ROW_W-1:0]       cell_row;
		logic [COL_W-1:0]       cell_column;
		logic [SCAN_W-1:0]      scan_line;
	} req_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic [POS_W-1:0]   pixel_x;
		logic [POS_W-1:0]   pixel_y;
		logic               last_pixel;
	} pix_t;

	// one fetched cell line handed to the pixel serialiser
	typedef struct packed {
		logic [GLYPH_W-1:0] bits;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic [COL_W-1:0]   col;
		logic [POS_W-1:0]   y;
	} ser_load_t;

endpackage

// ===== rtl/tcgr_ram.sv =====
// generic single write port, single read port ram with registered read
// no package dependencies; used for the glyph and palette stores

module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tcgr_pixel_ser.sv =====
// pixel serialiser: turns one fetched cell line into eight pixels behind an output register
// depends on tcgr_pkg

module tcgr_pixel_ser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	input  tcgr_pkg::ser_load_t load,
	output logic                free,
	output logic                pix_valid,
	input  logic                pix_ready,
	output tcgr_pkg::pix_t      pix
);

	import tcgr_pkg::*;

	logic                 active_q;
	logic [PIX_IDX_W-1:0] cnt_q;
	logic [GLYPH_W-1:0]   bits_q;
	logic [COLOR_W-1:0]   fg_q;
	logic [COLOR_W-1:0]   bg_q;
	logic [COL_W-1:0]     col_q;
	logic [POS_W-1:0]     y_q;
	logic                 pix_valid_q;
	pix_t                 pix_q;
	logic                 advance;
	logic                 take;

	// a pixel moves into the output register when it is empty or being drained
	assign advance = active_q && (!pix_valid_q || pix_ready);
	assign free    = !active_q || (advance && cnt_q == PIX_LAST);
	assign take    = load_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			if (take) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (advance) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == PIX_LAST) begin
					active_q <= 1'b0;
				end
			end
			if (advance) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bits_q <= load.bits;
			fg_q   <= load.fg;
			bg_q   <= load.bg;
			col_q  <= load.col;
			y_q    <= load.y;
		end else if (advance) begin
			bits_q <= {bits_q[GLYPH_W-2:0], 1'b0};
		end
		if (advance) begin
			pix_q.pixel_color <= bits_q[GLYPH_W-1] ? fg_q : bg_q;
			pix_q.pixel_x     <= {col_q, cnt_q};
			pix_q.pixel_y     <= y_q;
			pix_q.last_pixel  <= (cnt_q == PIX_LAST);
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (active_q && cnt_q == '0))
		else $error("serialiser did not start a new cell line");

	a_no_early_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cnt_q != PIX_LAST) |=> active_q)
		else $error("serialiser stopped before the eighth pixel");

	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_q && pix_q.last_pixel) |-> (pix_q.pixel_x[PIX_IDX_W-1:0] == PIX_LAST))
		else $error("last pixel flag not on the eighth pixel");

endmodule

// ===== rtl/text_cell_glyph_renderer.sv =====
// text cell glyph renderer: a render request in range yields eight pixels, one per cycle when pix_ready
// holds; the first pixel passes the ram read at the edge that takes the request, the serialiser load
// and the output register. while a fetched cell line waits for the busy serialiser, no new request,
// load or render, is taken; load requests give no pixels.
// arst_n clears control state and sets cell height 16, font select off; the glyph and palette
// rams are not cleared and hold nothing defined until written. depends on tcgr_pkg

module text_cell_glyph_renderer #(
	parameter int GLYPH_LINES = tcgr_pkg::GLYPH_LINES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  tcgr_pkg::req_t                   req,
	output logic                             pix_valid,
	input  logic                             pix_ready,
	output tcgr_pkg::pix_t                   pix,
	input  logic                             cfg_wr_en,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcgr_pkg::CFG_W-1:0]       cfg_data
);

	import tcgr_pkg::*;

	localparam int GLYPH_BYTES = 256 * GLYPH_LINES;
	localparam int GIDX_W      = $clog2(GLYPH_BYTES);
	localparam int GADDR_W     = GIDX_W + 1;
	localparam int PAL_AW      = $clog2(PALETTE_DEPTH);

	logic [CFG_W-1:0]    cell_height_q;
	logic                font_sel_en_q;
	logic                req_fire;
	logic                is_render;
	logic [HEIGHT_W-1:0] height;
	logic                render_ok;
	logic                scan_in_glyph;
	logic                font_sec;
	logic [GIDX_W-1:0]   glyph_idx;
	logic [GADDR_W-1:0]  glyph_raddr;
	logic [GADDR_W-1:0]  glyph_waddr;
	logic                glyph_we;
	logic                pal_we;
	logic                rd_en;
	logic [Y_FULL_W-1:0] y_full;
	logic [GLYPH_W-1:0]  glyph_rdata;
	logic [COLOR_W-1:0]  fg_rdata;
	logic [COLOR_W-1:0]  bg_rdata;
	logic                valid_s1;
	logic                zero_s1;
	logic [COL_W-1:0]    col_s1;
	logic [POS_W-1:0]    y_s1;
	logic                ser_free;
	ser_load_t           ser_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_height_q <= CELL_HEIGHT_RST;
			font_sel_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CELL_HEIGHT: cell_height_q <= cfg_data;
				REG_FONT_SEL:    font_sel_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a held cell line keeps the ram read data, so nothing new is taken until it moves on
	assign req_ready = !valid_s1 || ser_free;
	assign req_fire  = req_valid && req_ready;
	assign is_render = (req.opcode == OP_RENDER);

	assign height = (cell_height_q == '0) ? HEIGHT_W'(DEFAULT_CELL_HEIGHT)
		: HEIGHT_W'(cell_height_q);
	assign render_ok = (HEIGHT_W'(req.scan_line) < height)
		&& (int'(req.cell_row) < MAX_ROWS)
		&& (int'(req.cell_column) < MAX_COLUMNS);
	assign scan_in_glyph = (int'(req.scan_line) < GLYPH_LINES);

	assign font_sec    = font_sel_en_q && req.attribute_byte[3];
	assign glyph_idx   = GIDX_W'(int'(req.character_code) * GLYPH_LINES + int'(req.scan_line));
	assign glyph_raddr = {font_sec, glyph_idx};
	assign rd_en       = req_fire && is_render && render_ok;

	// both fonts share one ram, the secondary in the upper half
	assign glyph_we = req_fire && (req.opcode == OP_LOAD_PRI || req.opcode == OP_LOAD_SEC)
		&& (int'(req.load_address) < GLYPH_BYTES);
	assign glyph_waddr = {(req.opcode == OP_LOAD_SEC), GIDX_W'(req.load_address)};
	assign pal_we = req_fire && (req.opcode == OP_LOAD_PAL)
		&& (int'(req.load_address) < PALETTE_DEPTH);

	assign y_full = Y_FULL_W'(req.cell_row) * Y_FULL_W'(height) + Y_FULL_W'(req.scan_line);

	tcgr_ram #(
		.WIDTH (GLYPH_W),
		.DEPTH (2 * GLYPH_BYTES)
	) u_glyph_ram (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (glyph_waddr),
		.wdata (req.load_value[GLYPH_W-1:0]),
		.re    (rd_en),
		.raddr (glyph_raddr),
		.rdata (glyph_rdata)
	);

	// palette kept twice so foreground and background read in the same cycle
	tcgr_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_fg_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (PAL_AW'(req.load_address)),
		.wdata (req.load_value),
		.re    (rd_en),
		.raddr (req.attribute_byte[3:0]),
		.rdata (fg_rdata)
	);

	tcgr_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_bg_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (PAL_AW'(req.load_address)),
		.wdata (req.load_value),
		.re    (rd_en),
		.raddr (req.attribute_byte[7:4]),
		.rdata (bg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= is_render && render_ok;
		end else if (ser_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			zero_s1 <= !scan_in_glyph;
			col_s1  <= req.cell_column;
			y_s1    <= y_full[POS_W-1:0];
		end
	end

	// scan lines past the glyph height show background only
	assign ser_load.bits = zero_s1 ? '0 : glyph_rdata;
	assign ser_load.fg   = fg_rdata;
	assign ser_load.bg   = bg_rdata;
	assign ser_load.col  = col_s1;
	assign ser_load.y    = y_s1;

	tcgr_pixel_ser u_pixel_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load       (ser_load),
		.free       (ser_free),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix)
	);

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ser_free) |=> valid_s1)
		else $error("fetched cell line dropped while serialiser busy");

	a_render_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> valid_s1)
		else $error("accepted render request lost after ram read");

	a_load_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && !is_render) |=> !valid_s1)
		else $error("load request left a cell line pending");

endmodule
